/* hdl/touch_point_correlation_filter_unit_assert.svh */
// Assertion macros used by the checker file tpcf_checker.sv
`ifndef TOUCH_POINT_CORRELATION_FILTER_UNIT_ASSERT_SVH
`define TOUCH_POINT_CORRELATION_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset
`define TPCF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define TPCF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tpcf_pkg.sv */
package tpcf_pkg;

  // Coordinate width range and default
  localparam int COORD_BITS_DEF = 16;
  localparam int COORD_BITS_MAX = 24;

  // Port widths
  localparam int IN_COORD_W = 16;
  localparam int PRESS_W    = 10;
  localparam int OUT_COORD_W = 12;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Correlation arithmetic
  localparam int VEC_LIMIT = 31;
  localparam int FRAC_BITS = 10;
  localparam int SCORE_ONE = 1 << FRAC_BITS;
  localparam int SUBPIX_BITS = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER_X     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER_Y     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THR  = 2'd3;

endpackage

/* hdl/touch_point_correlation_filter_unit.sv */
// Touch point correlation filter.
// A release or a point that needs no scoring goes from START to FINISH; each direction score
// runs load, halving until the vectors fit in 5 bits, multiply steps, check, divide and fold,
// at most three scores per item.
// One item at a time; output stalls delay the result and so the next item.
// Reset (rst, synchronous): accepted point, counts and registers clear to zero, no pending item.
module touch_point_correlation_filter_unit import tpcf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // point_x[15:0], point_y[31:16], pressure[41:32]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // out_x[11:0], out_y[23:12]
  output logic                  m_tuser,   // valid_res
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = COORD_BITS;
  localparam int VW = COORD_BITS + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_LOAD, ST_SHIFT, ST_MUL, ST_CHECK, ST_DIV, ST_DONE, ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    CALL_LAST, CALL_FIRST, CALL_PAIR
  } call_t;

  state_t state;
  call_t  call;

  // Configuration
  logic signed [11:0] filter_level;
  logic [10:0] jitter_x, jitter_y;
  logic [PRESS_W-1:0] release_thr;

  // History
  logic signed [CW-1:0] acc_x, acc_y, cand0_x, cand0_y, cand1_x, cand1_y;
  logic has_acc;
  logic [1:0] cand_cnt;

  // Current item
  logic signed [CW-1:0] px, py;
  logic [PRESS_W-1:0] pr;
  logic released, did_corr;

  // Score working registers
  logic signed [VW-1:0] v1x, v1y, v2x, v2y;
  logic same_cell;
  logic [2:0] mstep;
  logic [11:0] s1, s2;
  logic signed [11:0] nacc;
  logic [21:0] dval, nsq;
  logic [31:0] rem, dsh;
  logic [10:0] quo;
  logic [3:0] dcnt;
  logic neg;
  logic signed [11:0] best;
  logic sel;

  // Output register
  logic [OUT_COORD_W-1:0] out_x, out_y;
  logic out_valid;

  // Input coordinates sign-extended to COORD_BITS_MAX, wrapped to COORD_BITS at capture
  logic signed [COORD_BITS_MAX-1:0] in_x_ext, in_y_ext;
  assign in_x_ext = COORD_BITS_MAX'($signed(s_tdata[IN_COORD_W-1:0]));
  assign in_y_ext = COORD_BITS_MAX'($signed(s_tdata[2*IN_COORD_W-1:IN_COORD_W]));

  // Select the three points of the current score
  logic signed [CW-1:0] p0_x, p0_y, a_x, a_y, b_x, b_y;
  logic signed [CW-1:0] a_sx, a_sy, c_sx, c_sy;
  always_comb begin
    p0_x = has_acc ? acc_x : cand0_x;
    p0_y = has_acc ? acc_y : cand0_y;
    case (call)
      CALL_LAST: begin
        a_x = p0_x;
        a_y = p0_y;
        b_x = (cand_cnt == 2'd2) ? cand1_x : cand0_x;
        b_y = (cand_cnt == 2'd2) ? cand1_y : cand0_y;
      end
      CALL_FIRST: begin
        a_x = p0_x;
        a_y = p0_y;
        b_x = cand0_x;
        b_y = cand0_y;
      end
      CALL_PAIR: begin
        a_x = cand0_x;
        a_y = cand0_y;
        b_x = cand1_x;
        b_y = cand1_y;
      end
      default: begin
        a_x = p0_x;
        a_y = p0_y;
        b_x = cand0_x;
        b_y = cand0_y;
      end
    endcase
    a_sx = a_x >>> SUBPIX_BITS;
    a_sy = a_y >>> SUBPIX_BITS;
    c_sx = px >>> SUBPIX_BITS;
    c_sy = py >>> SUBPIX_BITS;
  end

  // Any vector component still beyond the 5-bit range
  logic too_big;
  assign too_big = (v1x > VEC_LIMIT) || (v1x < -VEC_LIMIT) ||
                   (v1y > VEC_LIMIT) || (v1y < -VEC_LIMIT) ||
                   (v2x > VEC_LIMIT) || (v2x < -VEC_LIMIT) ||
                   (v2y > VEC_LIMIT) || (v2y < -VEC_LIMIT);

  // Shared multiplier
  logic signed [11:0] mul_a, mul_b, n_abs;
  logic signed [23:0] prod;
  assign n_abs = nacc[11] ? -nacc : nacc;
  always_comb begin
    case (mstep)
      3'd0: begin mul_a = $signed(v1x[11:0]); mul_b = $signed(v1x[11:0]); end
      3'd1: begin mul_a = $signed(v1y[11:0]); mul_b = $signed(v1y[11:0]); end
      3'd2: begin mul_a = $signed(v2x[11:0]); mul_b = $signed(v2x[11:0]); end
      3'd3: begin mul_a = $signed(v2y[11:0]); mul_b = $signed(v2y[11:0]); end
      3'd4: begin mul_a = $signed(v1x[11:0]); mul_b = $signed(v2x[11:0]); end
      3'd5: begin mul_a = $signed(v1y[11:0]); mul_b = $signed(v2y[11:0]); end
      3'd6: begin mul_a = $signed(s1);        mul_b = $signed(s2);        end
      default: begin mul_a = n_abs;           mul_b = n_abs;              end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Score of the finished step and running best
  logic signed [11:0] score, quo_s, best_new;
  assign quo_s = $signed({1'b0, quo});
  assign score = neg ? -quo_s : quo_s;
  assign best_new = (score > best) ? score : best;

  // Jitter test against the last accepted point
  logic signed [CW-1:0] sx, sy, sx_sh, sy_sh;
  logic signed [VW-1:0] dxa, dya;
  logic [VW-1:0] adx, ady;
  logic in_jitter, take;
  always_comb begin
    sx = sel ? cand1_x : cand0_x;
    sy = sel ? cand1_y : cand0_y;
    sx_sh = sx >>> SUBPIX_BITS;
    sy_sh = sy >>> SUBPIX_BITS;
    dxa = VW'(sx) - VW'(acc_x);
    dya = VW'(sy) - VW'(acc_y);
    adx = dxa[VW-1] ? VW'(-dxa) : VW'(dxa);
    ady = dya[VW-1] ? VW'(-dya) : VW'(dya);
    in_jitter = ((adx >> SUBPIX_BITS) <= VW'(jitter_x)) &&
                ((ady >> SUBPIX_BITS) <= VW'(jitter_y));
    take = did_corr && (best > filter_level);
  end

  assign s_tready = (state == ST_IDLE);
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      call         <= CALL_LAST;
      m_tvalid     <= 1'b0;
      has_acc      <= 1'b0;
      cand_cnt     <= 2'd0;
      acc_x        <= '0;
      acc_y        <= '0;
      filter_level <= '0;
      jitter_x     <= '0;
      jitter_y     <= '0;
      release_thr  <= '0;
    end else begin
      // Take configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_FILTER_LEVEL: filter_level <= $signed(cfg_wdata);
          REG_JITTER_X:     jitter_x <= cfg_wdata[10:0];
          REG_JITTER_Y:     jitter_y <= cfg_wdata[10:0];
          REG_RELEASE_THR:  release_thr <= cfg_wdata[PRESS_W-1:0];
          default: ;
        endcase
      end

      // Drop the output item once taken, unless a new one replaces it
      if (m_tvalid && m_tready && state != ST_FINISH) m_tvalid <= 1'b0;

      case (state)
        // Capture an item
        ST_IDLE: begin
          if (s_tvalid) begin
            px <= in_x_ext[CW-1:0];
            py <= in_y_ext[CW-1:0];
            pr <= s_tdata[2*IN_COORD_W+PRESS_W-1:2*IN_COORD_W];
            state <= ST_START;
          end
        end

        // Decide between release, scoring and plain append
        ST_START: begin
          released <= pr < release_thr;
          did_corr <= 1'b0;
          call <= CALL_LAST;
          if (pr < release_thr) begin
            state <= ST_FINISH;
          end else if (cand_cnt > 2'd1 || (cand_cnt != 2'd0 && has_acc)) begin
            did_corr <= 1'b1;
            state <= ST_LOAD;
          end else begin
            state <= ST_FINISH;
          end
        end

        // Form the two direction vectors
        ST_LOAD: begin
          v1x <= VW'(b_x) - VW'(a_x);
          v1y <= VW'(b_y) - VW'(a_y);
          v2x <= VW'(px) - VW'(b_x);
          v2y <= VW'(py) - VW'(b_y);
          same_cell <= (a_sx == c_sx) && (a_sy == c_sy);
          state <= ST_SHIFT;
        end

        // Halve all components until they fit in 5 bits
        ST_SHIFT: begin
          if (too_big) begin
            v1x <= v1x >>> 1;
            v1y <= v1y >>> 1;
            v2x <= v2x >>> 1;
            v2y <= v2y >>> 1;
          end else begin
            mstep <= 3'd0;
            state <= ST_MUL;
          end
        end

        // Norms, dot product and the two wide products
        ST_MUL: begin
          case (mstep)
            3'd0: s1 <= prod[11:0];
            3'd1: s1 <= s1 + prod[11:0];
            3'd2: s2 <= prod[11:0];
            3'd3: s2 <= s2 + prod[11:0];
            3'd4: nacc <= $signed(prod[11:0]);
            3'd5: nacc <= nacc + $signed(prod[11:0]);
            3'd6: dval <= prod[21:0];
            default: nsq <= prod[21:0];
          endcase
          mstep <= mstep + 3'd1;
          if (mstep == 3'd7) state <= ST_CHECK;
        end

        // Handle degenerate cases or start the division
        ST_CHECK: begin
          neg <= (dval != '0) && !same_cell && nacc[11];
          if (dval == '0) begin
            quo <= 11'(SCORE_ONE);
            state <= ST_DONE;
          end else if (same_cell) begin
            quo <= '0;
            state <= ST_DONE;
          end else begin
            rem <= {nsq, FRAC_BITS'(0)};
            dsh <= {dval, FRAC_BITS'(0)};
            quo <= '0;
            dcnt <= 4'(FRAC_BITS);
            state <= ST_DIV;
          end
        end

        // One quotient bit per cycle
        ST_DIV: begin
          if (rem >= dsh) rem <= rem - dsh;
          quo <= {quo[9:0], rem >= dsh};
          dsh <= dsh >> 1;
          dcnt <= dcnt - 4'd1;
          if (dcnt == 4'd0) state <= ST_DONE;
        end

        // Fold the score into the best and pick the next score
        ST_DONE: begin
          case (call)
            CALL_LAST: begin
              best <= score;
              sel <= cand_cnt == 2'd2;
              if (cand_cnt == 2'd2) begin
                call <= CALL_FIRST;
                state <= ST_LOAD;
              end else begin
                state <= ST_FINISH;
              end
            end
            CALL_FIRST: begin
              best <= best_new;
              if (score > best) sel <= 1'b0;
              if (best_new <= filter_level) begin
                call <= CALL_PAIR;
                state <= ST_LOAD;
              end else begin
                state <= ST_FINISH;
              end
            end
            default: begin
              best <= best_new;
              if (score > best) sel <= 1'b1;
              state <= ST_FINISH;
            end
          endcase
        end

        // Update history and present the result once the output is free
        ST_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_valid <= 1'b0;
            out_x <= '0;
            out_y <= '0;
            if (released) begin
              has_acc <= 1'b0;
              cand_cnt <= 2'd0;
            end else if (take) begin
              if (!(has_acc && in_jitter)) begin
                acc_x <= sx;
                acc_y <= sy;
                has_acc <= 1'b1;
                out_valid <= 1'b1;
                out_x <= sx_sh[OUT_COORD_W-1:0];
                out_y <= sy_sh[OUT_COORD_W-1:0];
              end
              cand0_x <= px;
              cand0_y <= py;
              cand_cnt <= 2'd1;
            end else if (cand_cnt == 2'd2) begin
              cand0_x <= cand1_x;
              cand0_y <= cand1_y;
              cand1_x <= px;
              cand1_y <= py;
            end else if (cand_cnt == 2'd1) begin
              cand1_x <= px;
              cand1_y <= py;
              cand_cnt <= 2'd2;
            end else begin
              cand0_x <= px;
              cand0_y <= py;
              cand_cnt <= 2'd1;
            end
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {out_y, out_x};
  assign m_tuser = out_valid;

endmodule

/* hdl/tpcf_checker.sv */
`include "touch_point_correlation_filter_unit_assert.svh"

module tpcf_checker import tpcf_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tuser
);

  // Hold a stalled output item
  `TPCF_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output item changed while stalled")

  // A point that is not reported reads as zero
  `TPCF_ASSERT_NOW(a_invalid_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0, "unreported point carries data")

  // Busy right after taking an item
  `TPCF_ASSERT_NEXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while item in work")

endmodule

bind touch_point_correlation_filter_unit tpcf_checker u_tpcf_checker (.*);

/* verif/tb_touch_point_correlation_filter_unit.sv */
`timescale 1ns / 100ps

module tb_touch_point_correlation_filter_unit;
  import tpcf_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int RAND_ITEMS = 1250;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;   // out_x[11:0], out_y[23:12]
  logic                  m_tuser;   // valid_res
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  touch_point_correlation_filter_unit #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic              hit;
    logic signed [11:0] ox;
    logic signed [11:0] oy;
  } point_out_t;

  typedef struct {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [9:0]         pr;
    logic               known;   // expected result typed in
    point_out_t         want;
  } stim_row_t;

  // Filter copy kept in step with the block
  longint lvl, jit_x, jit_y, rel_thr;
  longint acc_x, acc_y;
  bit     acc_ok;
  longint cand_x[2], cand_y[2];
  int     cand_n;

  point_out_t pending_pts[$];
  int errors = 0;
  int sent = 0, got = 0, reported = 0;

  task automatic report(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Signed squared-cosine direction score of a->b->c
  function automatic longint score3(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy);
    longint ux, uy, wx, wy, d, n;
    ux = bx - ax; uy = by - ay; wx = cx - bx; wy = cy - by;
    while (mag(ux) > VEC_LIMIT || mag(uy) > VEC_LIMIT ||
           mag(wx) > VEC_LIMIT || mag(wy) > VEC_LIMIT) begin
      ux = fshr(ux, 1); uy = fshr(uy, 1); wx = fshr(wx, 1); wy = fshr(wy, 1);
    end
    d = (ux * ux + uy * uy) * (wx * wx + wy * wy);
    if (d == 0) return SCORE_ONE;
    if (fshr(ax, SUBPIX_BITS) == fshr(cx, SUBPIX_BITS) &&
        fshr(ay, SUBPIX_BITS) == fshr(cy, SUBPIX_BITS)) return 0;
    n = ux * wx + uy * wy;
    return (n * mag(n) * SCORE_ONE) / d;
  endfunction

  function automatic void shift_in(longint px, longint py);
    if (cand_n == 2) begin
      cand_x[0] = cand_x[1]; cand_y[0] = cand_y[1]; cand_n = 1;
    end
    cand_x[cand_n] = px; cand_y[cand_n] = py; cand_n++;
  endfunction

  function automatic point_out_t filter_point(logic signed [15:0] ix,
                                              logic signed [15:0] iy, logic [9:0] pr);
    point_out_t r;
    longint px, py, p0x, p0y, c1, c2, sx, sy;
    int sel;
    r = '0;
    px = ix; py = iy;
    if (pr < rel_thr) begin
      acc_ok = 0; cand_n = 0;
      return r;
    end
    if (cand_n > 1 || (cand_n > 0 && acc_ok)) begin
      p0x = acc_ok ? acc_x : cand_x[0];
      p0y = acc_ok ? acc_y : cand_y[0];
      sel = cand_n - 1;
      c1 = score3(p0x, p0y, cand_x[sel], cand_y[sel], px, py);
      if (cand_n > 1) begin
        c2 = score3(p0x, p0y, cand_x[0], cand_y[0], px, py);
        if (c2 > c1) begin c1 = c2; sel = 0; end
      end
      if (c1 <= lvl && cand_n > 1) begin
        c2 = score3(cand_x[0], cand_y[0], cand_x[1], cand_y[1], px, py);
        if (c2 > c1) begin c1 = c2; sel = 1; end
      end
      if (c1 > lvl) begin
        sx = cand_x[sel]; sy = cand_y[sel];
        if (!(acc_ok && (mag(sx - acc_x) >> 4) <= jit_x && (mag(sy - acc_y) >> 4) <= jit_y))
        begin
          acc_x = sx; acc_y = sy; acc_ok = 1;
          r.hit = 1'b1;
          r.ox = 12'(fshr(sx, SUBPIX_BITS));
          r.oy = 12'(fshr(sy, SUBPIX_BITS));
        end
        cand_x[0] = px; cand_y[0] = py; cand_n = 1;
        return r;
      end
    end
    shift_in(px, py);
    return r;
  endfunction

  // Idle pattern; 0 none, 1 sender, 2 receiver, 3 both
  int phase_mode = 0;

  // Receiver side: random stall and result check
  always @(posedge clk) begin
    point_out_t seen, exp_pt;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        seen = {m_tuser, m_tdata[11:0], m_tdata[23:12]};
        got++;
        if (seen.hit) reported++;
        if (pending_pts.size() == 0) begin
          report("result with nothing expected");
        end else begin
          exp_pt = pending_pts.pop_front();
          if (seen.hit !== exp_pt.hit)
            report($sformatf("valid_res %b want %b", seen.hit, exp_pt.hit));
          if (seen.ox !== exp_pt.ox)
            report($sformatf("out_x %0d want %0d", seen.ox, exp_pt.ox));
          if (seen.oy !== exp_pt.oy)
            report($sformatf("out_y %0d want %0d", seen.oy, exp_pt.oy));
        end
      end
      if (phase_mode == 2) m_tready <= ($urandom_range(99) >= 83);
      else if (phase_mode == 3) m_tready <= ($urandom_range(99) >= 27);
      else m_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FILTER_LEVEL: lvl = longint'($signed(val));
      REG_JITTER_X:     jit_x = longint'(val[10:0]);
      REG_JITTER_Y:     jit_y = longint'(val[10:0]);
      REG_RELEASE_THR:  rel_thr = longint'(val[9:0]);
      default: ;
    endcase
  endtask

  // Present one item; the first idle draw happens before it is offered
  task automatic send_point(logic signed [15:0] px, logic signed [15:0] py, logic [9:0] pr,
                            bit known, point_out_t want);
    point_out_t e;
    int gap;
    gap = 0;
    if (phase_mode == 1 || phase_mode == 3) begin
      while ($urandom_range(99) < (phase_mode == 1 ? 83 : 27)) gap++;
      if (gap > 40) gap = 40;
    end
    // Hold valid low through the idle gap
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, pr, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    e = filter_point(px, py, pr);
    if (known && e !== want) report("directed row disagrees with filter copy");
    pending_pts.push_back(e);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic point_out_t pt(logic h, int x, int y);
    point_out_t r;
    r.hit = h; r.ox = 12'(x); r.oy = 12'(y);
    return r;
  endfunction

  // Random item: mostly smooth strokes, some jumps, releases and noise
  longint stroke_x, stroke_y, vel_x, vel_y;

  task automatic random_point();
    logic signed [15:0] px, py;
    logic [9:0] pr;
    int k;
    k = $urandom_range(99);
    if (k < 6) begin
      px = 16'($urandom); py = 16'($urandom); pr = 10'($urandom);
    end else begin
      if (k < 12) begin
        stroke_x = $signed(16'($urandom)); stroke_y = $signed(16'($urandom));
        vel_x = $signed(9'($urandom)); vel_y = $signed(9'($urandom));
      end
      if ($urandom_range(9) == 0) begin
        vel_x += $signed(6'($urandom)); vel_y += $signed(6'($urandom));
      end
      stroke_x += vel_x + $signed(4'($urandom));
      stroke_y += vel_y + $signed(4'($urandom));
      px = 16'(stroke_x); py = 16'(stroke_y);
      pr = ($urandom_range(19) == 0) ? 10'($urandom_range(rel_thr)) : 10'($urandom);
      if (rel_thr > 0 && $urandom_range(4) != 0 && pr < rel_thr) pr = 10'd1023;
    end
    send_point(px, py, pr, 1'b0, '0);
  endtask

  stim_row_t rows[$];

  initial begin
    lvl = 0; jit_x = 0; jit_y = 0; rel_thr = 0;
    acc_x = 0; acc_y = 0; acc_ok = 0; cand_n = 0;
    stroke_x = 0; stroke_y = 0; vel_x = 40; vel_y = 20;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    m_tready <= 1'b1;

    // After reset: first two points only fill candidates, third scores straight line
    rows.push_back('{16'sd0, 16'sd0, 10'd0, 1'b1, pt(0, 0, 0)});
    rows.push_back('{16'sd160, 16'sd160, 10'd0, 1'b1, pt(0, 0, 0)});
    rows.push_back('{16'sd320, 16'sd320, 10'd1023, 1'b1, pt(1, 10, 10)});
    rows.push_back('{16'sd480, 16'sd480, 10'd512, 1'b1, pt(1, 20, 20)});
    // Extremes of the coordinates, wrapped reported values
    rows.push_back('{16'sh7fff, 16'sh8000, 10'd1023, 1'b0, '0});
    rows.push_back('{-16'sd32768, 16'sh7fff, 10'd0, 1'b0, '0});
    rows.push_back('{16'sh7fff, 16'sh7fff, 10'd1023, 1'b0, '0});
    rows.push_back('{16'sh7ff0, -16'sd32768, 10'd1023, 1'b0, '0});
    // Reversal, zero vector, shared cell
    rows.push_back('{16'sd0, 16'sd0, 10'd1, 1'b0, '0});
    rows.push_back('{16'sd0, 16'sd0, 10'd2, 1'b0, '0});
    rows.push_back('{16'sd5, 16'sd3, 10'd3, 1'b0, '0});
    rows.push_back('{-16'sd400, 16'sd100, 10'd4, 1'b0, '0});
    rows.push_back('{16'sd400, -16'sd100, 10'd5, 1'b0, '0});
    rows.push_back('{-16'sd1, -16'sd1, 10'd6, 1'b0, '0});
    foreach (rows[i]) send_point(rows[i].px, rows[i].py, rows[i].pr, rows[i].known,
                                 rows[i].want);
    drain();

    // Release threshold, jitter and level extremes
    write_reg(REG_RELEASE_THR, 12'd1023);
    write_reg(REG_FILTER_LEVEL, 12'h400);
    send_point(16'sd100, 16'sd100, 10'd1022, 1'b1, pt(0, 0, 0));
    send_point(16'sd100, 16'sd100, 10'd1023, 1'b0, '0);
    send_point(16'sd100, 16'sd100, 10'd0, 1'b1, pt(0, 0, 0));
    drain();
    write_reg(REG_FILTER_LEVEL, 12'hc00);
    write_reg(REG_JITTER_X, 12'd2047);
    write_reg(REG_JITTER_Y, 12'd2047);
    write_reg(REG_RELEASE_THR, 12'd0);
    for (int i = 0; i < 6; i++) send_point(16'(i * 300), 16'(-i * 200), 10'd9, 1'b0, '0);
    drain();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      phase_mode = ph % 4;
      case (ph)
        0: begin write_reg(REG_FILTER_LEVEL, 12'd0); write_reg(REG_JITTER_X, 12'd0);
                 write_reg(REG_JITTER_Y, 12'd0); write_reg(REG_RELEASE_THR, 12'd50); end
        1: begin write_reg(REG_FILTER_LEVEL, 12'd700); write_reg(REG_JITTER_X, 12'd3);
                 write_reg(REG_JITTER_Y, 12'd2); end
        2: begin write_reg(REG_FILTER_LEVEL, 12'hc00); write_reg(REG_RELEASE_THR, 12'd0); end
        3: begin write_reg(REG_FILTER_LEVEL, 12'h400); write_reg(REG_RELEASE_THR, 12'd1023); end
        default: begin
          write_reg(REG_FILTER_LEVEL, 12'($urandom_range(2048) - 1024));
          write_reg(REG_JITTER_X, 12'($urandom_range(4)));
          write_reg(REG_JITTER_Y, 12'($urandom_range(4)));
          write_reg(REG_RELEASE_THR, 12'($urandom_range(200)));
        end
      endcase
      for (int i = 0; i < RAND_ITEMS / 8; i++) random_point();
      drain();
    end
    phase_mode = 0;

    $display("covered %0d items, %0d results, %0d reported points", sent, got, reported);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20ms;
    $display("timeout after %0d items", sent);
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tpcf_pkg.sv
hdl/touch_point_correlation_filter_unit.sv
hdl/tpcf_checker.sv
verif/tb_touch_point_correlation_filter_unit.sv
